/* hw/rtl/cover_fit_nearest_scaler_map_assert.svh */
// cover_fit_nearest_scaler_map_assert.svh: assertion macros for the scaler map checker
// no dependencies; included by the checker file
`ifndef COVER_FIT_NEAREST_SCALER_MAP_ASSERT_SVH
`define COVER_FIT_NEAREST_SCALER_MAP_ASSERT_SVH

// same-cycle implication, disabled during reset
`define CFNS_ASSERT_IMPL(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("cfns assertion failed");

// next-cycle implication, disabled during reset
`define CFNS_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("cfns assertion failed");

`endif

/* hw/rtl/cfns_pkg.sv */
`timescale 1ns / 1ps
// cfns_pkg: widths, register indexes, payload types and control structs
// for the cover-fit nearest scaler map; no dependencies
package cfns_pkg;

  localparam int DIM_W             = 13;
  localparam int COORD_W           = 12;
  localparam int PITCH_W           = 16;
  localparam int OFF_W             = 28;
  localparam int DIV_W             = 2 * DIM_W;
  localparam int MAX_DIMENSION_DEF = 4096;
  localparam int CFG_IDX_W         = 3;
  localparam int CFG_DATA_W        = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT    = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_WIDTH    = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_HEIGHT   = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_ROW_PITCH = CFG_IDX_W'(4);

  // which division the shared divider runs
  typedef enum logic [1:0] {
    DIV_CROP,
    DIV_STEP_X,
    DIV_STEP_Y
  } div_sel_e;

  typedef struct packed {
    logic [COORD_W-1:0] out_column;
    logic [COORD_W-1:0] out_row;
  } in_t;

  typedef struct packed {
    logic [COORD_W-1:0] source_x;
    logic [COORD_W-1:0] source_y;
    logic [OFF_W-1:0]   byte_offset;
    logic               in_range;
  } out_t;

  typedef struct packed {
    logic     load_in;
    logic     prod_load;
    logic     div_start;
    div_sel_e div_sel;
    logic     crop_load;
    logic     stepx_load;
    logic     stepy_load;
    logic     sweep_init;
    logic     sweep_step;
    logic     rd;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic cfg_wr;
    logic cfg_ok;
    logic div_done;
    logic sweep_last;
  } status_t;

endpackage

/* hw/rtl/cfns_div.sv */
`timescale 1ns / 1ps
// cfns_div: restoring divider, one quotient bit per cycle
// depends on cfns_pkg
module cfns_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [cfns_pkg::DIV_W-1:0]   dividend_i,
  input  logic [cfns_pkg::DIM_W-1:0]   divisor_i,
  output logic                         done_o,
  output logic [cfns_pkg::DIV_W-1:0]   quotient_o,
  output logic [cfns_pkg::DIM_W-1:0]   remainder_o
);
  import cfns_pkg::*;

  localparam int CNT_W = $clog2(DIV_W);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DIV_W-1:0] dvd_q, dvd_d;
  logic [DIM_W-1:0] rem_q, rem_d;
  logic [DIM_W-1:0] dvs_q, dvs_d;
  logic [DIM_W:0]   trial;
  logic [DIM_W:0]   diff;
  logic             ge;

  always_comb begin
    trial  = {rem_q, dvd_q[DIV_W-1]};
    diff   = trial - {1'b0, dvs_q};
    ge     = trial >= {1'b0, dvs_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      // quotient bits shift in where dividend bits shift out
      dvd_d = {dvd_q[DIV_W-2:0], ge};
      rem_d = ge ? diff[DIM_W-1:0] : trial[DIM_W-1:0];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(DIV_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o      = done_q;
  assign quotient_o  = dvd_q;
  assign remainder_o = rem_q;

endmodule

/* hw/rtl/cfns_dp.sv */
`timescale 1ns / 1ps
// cfns_dp: configuration registers, crop setup, map memories and offset datapath
// depends on cfns_pkg and cfns_div
module cfns_dp #(
  parameter int MAX_DIMENSION = cfns_pkg::MAX_DIMENSION_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  input  logic [cfns_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [cfns_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  cfns_pkg::in_t                   in_data_i,
  input  cfns_pkg::cmd_t                  cmd_i,
  output cfns_pkg::status_t               status_o,
  output cfns_pkg::out_t                  out_data_o
);
  import cfns_pkg::*;

  localparam int AW   = $clog2(MAX_DIMENSION);
  localparam int CMPW = (AW > DIM_W) ? AW : DIM_W;

  logic [DIM_W-1:0]   fw_q, fh_q, ow_q, oh_q;
  logic [PITCH_W-1:0] pitch_q;
  logic               cfg_wr;
  logic               cfg_ok;

  logic [COORD_W-1:0] col_q, row_q;
  logic [DIV_W-1:0]   prod_a_q, prod_b_q;
  logic               wide;

  logic [DIV_W-1:0]   div_dividend;
  logic [DIM_W-1:0]   div_divisor;
  logic               div_done;
  logic [DIV_W-1:0]   div_quot;
  logic [DIM_W-1:0]   div_rem;
  logic [DIM_W-1:0]   crop_new;

  logic [DIM_W-1:0]   crop_w_q, crop_h_q, org_x_q, org_y_q;
  logic [DIM_W-1:0]   qsx_q, rsx_q, qsy_q, rsy_q;

  logic [AW-1:0]      idx_q;
  logic [DIM_W-1:0]   qx_q, rx_q, qy_q, ry_q;
  logic [DIM_W:0]     rx_sum, ry_sum;
  logic               rx_wrap, ry_wrap;
  logic [DIM_W:0]     vx, vy;
  logic [DIM_W-1:0]   lim_x, lim_y;
  logic [DIM_W-1:0]   mx, my;
  logic [DIM_W-1:0]   n_max;
  logic               col_we, row_we;

  // entries keep the full source coordinate; only the result fields are masked
  logic [DIM_W-1:0]   col_mem [MAX_DIMENSION];
  logic [DIM_W-1:0]   row_mem [MAX_DIMENSION];
  logic [DIM_W-1:0]   sx_q, sy_q;

  logic               in_range;
  logic [OFF_W-1:0]   off_prod;
  logic [OFF_W-1:0]   off;
  out_t               out_q;

  // configuration registers
  always_comb begin
    unique case (cfg_index_i)
      REG_FRAME_WIDTH, REG_FRAME_HEIGHT, REG_OUTPUT_WIDTH,
      REG_OUTPUT_HEIGHT, REG_FRAME_ROW_PITCH: cfg_wr = cfg_valid_i;
      default: cfg_wr = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q    <= '0;
      fh_q    <= '0;
      ow_q    <= '0;
      oh_q    <= '0;
      pitch_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_FRAME_WIDTH:     fw_q    <= cfg_data_i[DIM_W-1:0];
        REG_FRAME_HEIGHT:    fh_q    <= cfg_data_i[DIM_W-1:0];
        REG_OUTPUT_WIDTH:    ow_q    <= cfg_data_i[DIM_W-1:0];
        REG_OUTPUT_HEIGHT:   oh_q    <= cfg_data_i[DIM_W-1:0];
        REG_FRAME_ROW_PITCH: pitch_q <= cfg_data_i[PITCH_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_ok = (fw_q != '0) && (fh_q != '0) && (ow_q != '0) && (oh_q != '0)
               && (32'(fw_q) <= 32'(MAX_DIMENSION)) && (32'(fh_q) <= 32'(MAX_DIMENSION))
               && (32'(ow_q) <= 32'(MAX_DIMENSION)) && (32'(oh_q) <= 32'(MAX_DIMENSION))
               && (pitch_q >= PITCH_W'({fw_q, 2'b00}));

  // captured coordinates and aspect products
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      col_q <= in_data_i.out_column;
      row_q <= in_data_i.out_row;
    end
    if (cmd_i.prod_load) begin
      prod_a_q <= DIV_W'(fw_q) * DIV_W'(oh_q);
      prod_b_q <= DIV_W'(ow_q) * DIV_W'(fh_q);
    end
  end

  // frame relatively wider than the output: crop columns
  assign wide = prod_a_q > prod_b_q;

  always_comb begin
    unique case (cmd_i.div_sel)
      DIV_CROP: begin
        div_dividend = wide ? prod_b_q : prod_a_q;
        div_divisor  = wide ? oh_q : ow_q;
      end
      DIV_STEP_X: begin
        div_dividend = DIV_W'(crop_w_q);
        div_divisor  = ow_q;
      end
      DIV_STEP_Y: begin
        div_dividend = DIV_W'(crop_h_q);
        div_divisor  = oh_q;
      end
      default: begin
        div_dividend = '0;
        div_divisor  = ow_q;
      end
    endcase
  end

  cfns_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (cmd_i.div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (div_divisor),
    .done_o      (div_done),
    .quotient_o  (div_quot),
    .remainder_o (div_rem)
  );

  assign crop_new = div_quot[DIM_W-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.crop_load) begin
      if (wide) begin
        crop_w_q <= crop_new;
        crop_h_q <= fh_q;
        org_x_q  <= (fw_q - crop_new) >> 1;
        org_y_q  <= '0;
      end else begin
        crop_w_q <= fw_q;
        crop_h_q <= crop_new;
        org_x_q  <= '0;
        org_y_q  <= (fh_q - crop_new) >> 1;
      end
    end
    if (cmd_i.stepx_load) begin
      qsx_q <= div_quot[DIM_W-1:0];
      rsx_q <= div_rem;
    end
    if (cmd_i.stepy_load) begin
      qsy_q <= div_quot[DIM_W-1:0];
      rsy_q <= div_rem;
    end
  end

  // map sweep: i*crop/out tracked as quotient and remainder
  always_comb begin
    rx_sum  = {1'b0, rx_q} + {1'b0, rsx_q};
    ry_sum  = {1'b0, ry_q} + {1'b0, rsy_q};
    rx_wrap = rx_sum >= {1'b0, ow_q};
    ry_wrap = ry_sum >= {1'b0, oh_q};
    vx      = {1'b0, org_x_q} + {1'b0, qx_q};
    vy      = {1'b0, org_y_q} + {1'b0, qy_q};
    lim_x   = fw_q - 1'b1;
    lim_y   = fh_q - 1'b1;
    mx      = (vx > {1'b0, lim_x}) ? lim_x : vx[DIM_W-1:0];
    my      = (vy > {1'b0, lim_y}) ? lim_y : vy[DIM_W-1:0];
    n_max   = (ow_q > oh_q) ? ow_q : oh_q;
    col_we  = cmd_i.sweep_step && (CMPW'(idx_q) < CMPW'(ow_q));
    row_we  = cmd_i.sweep_step && (CMPW'(idx_q) < CMPW'(oh_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (cmd_i.sweep_init) begin
      idx_q <= '0;
    end else if (cmd_i.sweep_step) begin
      idx_q <= idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sweep_init) begin
      qx_q <= '0;
      rx_q <= '0;
      qy_q <= '0;
      ry_q <= '0;
    end else if (cmd_i.sweep_step) begin
      qx_q <= qx_q + qsx_q + DIM_W'(rx_wrap);
      rx_q <= rx_wrap ? DIM_W'(rx_sum - {1'b0, ow_q}) : rx_sum[DIM_W-1:0];
      qy_q <= qy_q + qsy_q + DIM_W'(ry_wrap);
      ry_q <= ry_wrap ? DIM_W'(ry_sum - {1'b0, oh_q}) : ry_sum[DIM_W-1:0];
    end
  end

  // map memories, registered read
  always_ff @(posedge clk_i) begin
    if (col_we) begin
      col_mem[idx_q] <= mx;
    end
    if (cmd_i.rd) begin
      sx_q <= col_mem[AW'(col_q)];
    end
  end

  always_ff @(posedge clk_i) begin
    if (row_we) begin
      row_mem[idx_q] <= my;
    end
    if (cmd_i.rd) begin
      sy_q <= row_mem[AW'(row_q)];
    end
  end

  // byte offset from the full coordinates, then wrapped to the field width
  assign in_range = cfg_ok && ({1'b0, col_q} < ow_q) && ({1'b0, row_q} < oh_q);
  assign off_prod = OFF_W'(sy_q) * OFF_W'(pitch_q);
  assign off      = off_prod + OFF_W'({sx_q, 2'b00});

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      if (in_range) begin
        out_q.source_x    <= sx_q[COORD_W-1:0];
        out_q.source_y    <= sy_q[COORD_W-1:0];
        out_q.byte_offset <= off;
        out_q.in_range    <= 1'b1;
      end else begin
        out_q <= '0;
      end
    end
  end

  assign out_data_o          = out_q;
  assign status_o.cfg_wr     = cfg_wr;
  assign status_o.cfg_ok     = cfg_ok;
  assign status_o.div_done   = div_done;
  assign status_o.sweep_last = CMPW'(idx_q) == CMPW'(n_max - 1'b1);

endmodule

/* hw/rtl/cfns_ctrl.sv */
`timescale 1ns / 1ps
// cfns_ctrl: sequencer for map rebuild and per-pixel lookup
// depends on cfns_pkg
module cfns_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  cfns_pkg::status_t status_i,
  output cfns_pkg::cmd_t    cmd_o
);
  import cfns_pkg::*;

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_PROD      = 4'd1;
  localparam logic [3:0] S_CROP_GO   = 4'd2;
  localparam logic [3:0] S_CROP_WAIT = 4'd3;
  localparam logic [3:0] S_X_GO      = 4'd4;
  localparam logic [3:0] S_X_WAIT    = 4'd5;
  localparam logic [3:0] S_Y_GO      = 4'd6;
  localparam logic [3:0] S_Y_WAIT    = 4'd7;
  localparam logic [3:0] S_SWEEP     = 4'd8;
  localparam logic [3:0] S_RD        = 4'd9;
  localparam logic [3:0] S_MUL       = 4'd10;

  logic [3:0] state_q, state_d;
  logic       cur_q, cur_d;
  logic       oval_q, oval_d;

  always_comb begin
    state_d = state_q;
    cur_d   = cur_q;
    oval_d  = oval_q;
    cmd_o   = '0;
    if (oval_q && out_ready_i) begin
      oval_d = 1'b0;
    end
    if (status_i.cfg_wr) begin
      cur_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          if (status_i.cfg_ok && !cur_q) begin
            state_d = S_PROD;
          end else begin
            state_d = S_RD;
          end
        end
      end
      S_PROD: begin
        cmd_o.prod_load = 1'b1;
        state_d         = S_CROP_GO;
      end
      S_CROP_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_CROP;
        state_d         = S_CROP_WAIT;
      end
      S_CROP_WAIT: begin
        cmd_o.div_sel = DIV_CROP;
        if (status_i.div_done) begin
          cmd_o.crop_load = 1'b1;
          state_d         = S_X_GO;
        end
      end
      S_X_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_STEP_X;
        state_d         = S_X_WAIT;
      end
      S_X_WAIT: begin
        cmd_o.div_sel = DIV_STEP_X;
        if (status_i.div_done) begin
          cmd_o.stepx_load = 1'b1;
          state_d          = S_Y_GO;
        end
      end
      S_Y_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_STEP_Y;
        state_d         = S_Y_WAIT;
      end
      S_Y_WAIT: begin
        cmd_o.div_sel = DIV_STEP_Y;
        if (status_i.div_done) begin
          cmd_o.stepy_load = 1'b1;
          cmd_o.sweep_init = 1'b1;
          state_d          = S_SWEEP;
        end
      end
      S_SWEEP: begin
        cmd_o.sweep_step = 1'b1;
        if (status_i.sweep_last) begin
          cur_d   = 1'b1;
          state_d = S_RD;
        end
      end
      S_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = S_MUL;
      end
      S_MUL: begin
        // result register must be free or emptying this cycle
        if (!oval_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          oval_d         = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cur_q   <= 1'b0;
      oval_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cur_q   <= cur_d;
      oval_q  <= oval_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = oval_q;

endmodule

/* hw/rtl/cover_fit_nearest_scaler_map.sv */
`timescale 1ns / 1ps
// cover_fit_nearest_scaler_map: top level of the cover-fit nearest-neighbor address map
// depends on cfns_pkg, cfns_ctrl, cfns_dp and cfns_div
//
// maps an output pixel (out_column, out_row) to the source frame pixel picked by
// aspect-preserving fill-and-crop scaling, plus its byte offset in a four-byte-per-pixel
// frame. a lookup transaction captures the coordinate in the accepting cycle, then does
// the registered read of the column and row maps (after a map rebuild, when one is due)
// and then the row-pitch multiply into the output register once that register is free
// or emptying. the block takes no new transaction while one is in flight; the next
// transaction is taken on the cycle after the result is loaded, even while that result
// still waits for out_ready_i. the first transaction after any write to a decoded
// configuration register, with a valid configuration, first rebuilds the maps: the aspect
// products, three serial divisions of 26 quotient bits in a shared one-bit-per-cycle
// divider, and then a sweep over the entries of the larger of output_width and
// output_height. an invalid configuration (a zero size, a size above MAX_DIMENSION, or a
// row pitch below four times the frame width) or a coordinate outside the output area
// returns in_range 0 with all other fields zero.
// configuration writes are always accepted and must only be issued while no transaction
// is in flight.
// register indexes: 0 frame_width, 1 frame_height, 2 output_width, 3 output_height,
// 4 frame_row_pitch; other indexes are ignored
module cover_fit_nearest_scaler_map #(
  parameter int MAX_DIMENSION = cfns_pkg::MAX_DIMENSION_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration write channel
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [cfns_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [cfns_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // coordinate input channel
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  cfns_pkg::in_t                   in_data_i,
  // mapped result channel
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output cfns_pkg::out_t                  out_data_o
);
  import cfns_pkg::*;

  cmd_t    cmd;
  status_t status;

  // configuration registers take a write every cycle
  assign cfg_ready_o = 1'b1;

  // sequencer: rebuild steps, lookup steps and the result valid flag
  cfns_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // registers, divider, map memories and offset arithmetic
  cfns_dp #(
    .MAX_DIMENSION (MAX_DIMENSION)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_data_o  (out_data_o)
  );

endmodule

/* hw/rtl/cfns_checker.sv */
`timescale 1ns / 1ps
// cfns_checker: port-level assertions for the cover-fit scaler map, bound to the top
// depends on cfns_pkg and cover_fit_nearest_scaler_map_assert.svh
`include "cover_fit_nearest_scaler_map_assert.svh"

module cfns_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_o,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input cfns_pkg::out_t out_data_o
);

  logic out_stall;
  logic out_miss;
  logic miss_fields_zero;
  logic in_fire;

  assign out_stall        = out_valid_o && !out_ready_i;
  assign out_miss         = out_valid_o && !out_data_o.in_range;
  assign miss_fields_zero = (out_data_o.source_x == '0) && (out_data_o.source_y == '0)
                         && (out_data_o.byte_offset == '0);
  assign in_fire          = in_valid_i && in_ready_o;

  // a stalled result holds
  `CFNS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, out_valid_o && $stable(out_data_o))

  // a miss carries all-zero fields
  `CFNS_ASSERT_IMPL(a_miss_zero, clk_i, rst_ni, out_miss, miss_fields_zero)

  // one coordinate in flight at a time
  `CFNS_ASSERT_NEXT(a_one_in_flight, clk_i, rst_ni, in_fire, !in_ready_o)

  // a new result only appears after the input side was busy working
  `CFNS_ASSERT_IMPL(a_result_after_work, clk_i, rst_ni, $rose(out_valid_o), !$past(in_ready_o))

endmodule

bind cover_fit_nearest_scaler_map cfns_checker u_checker (.*);

/* verif/cover_fit_nearest_scaler_map_tb.sv */
`timescale 1ns / 1ps
// cover_fit_nearest_scaler_map_tb: self-checking regression for the cover-fit scaler map
// depends on cfns_pkg and cover_fit_nearest_scaler_map; predicts each mapped pixel and
// compares it with what the block returns, under random idling on both channels
module cover_fit_nearest_scaler_map_tb;
  import cfns_pkg::*;

  localparam int MAX_DIM       = MAX_DIMENSION_DEF;
  localparam int COORD_MAX     = (1 << COORD_W) - 1;
  // longest rebuild is three serial divisions plus a sweep over a 4096-entry map,
  // with room left for receiver stalls
  localparam int QUIET_LIMIT   = 30000;
  // capture, map read and pitch multiply
  localparam int LATENCY_PAUSE = 16;
  localparam int MAX_REPORTS   = 100;

  // indexes the block decodes to nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = CFG_IDX_W'(5);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = CFG_IDX_W'(7);

  // idling modes
  localparam int IDLE_SENDER_LIGHT = 0;
  localparam int IDLE_SENDER_HEAVY = 1;
  localparam int IDLE_NONE         = 2;

  // block inputs, known from time zero
  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;
  logic                  in_valid_i  = 1'b0;
  in_t                   in_data_i   = '0;
  logic                  out_ready_i = 1'b0;

  logic cfg_ready_o;
  logic in_ready_o;
  logic out_valid_o;
  out_t out_data_o;

  cover_fit_nearest_scaler_map #(
    .MAX_DIMENSION(MAX_DIM)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always #10 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // predictor state: shadow registers and the cached column and row maps
  // ---------------------------------------------------------------------------
  logic [DIM_W-1:0]   frame_w   = '0;
  logic [DIM_W-1:0]   frame_h   = '0;
  logic [DIM_W-1:0]   out_w     = '0;
  logic [DIM_W-1:0]   out_h     = '0;
  logic [PITCH_W-1:0] row_pitch = '0;
  logic [COORD_W-1:0] col_lut [MAX_DIM];
  logic [COORD_W-1:0] row_lut [MAX_DIM];
  bit                 luts_fresh = 1'b0;

  // mapped pixels still owed by the block, oldest first
  out_t pending_maps [$];
  int   mismatch_count     = 0;
  int   sender_idle_pct    = 0;
  int   receiver_stall_pct = 0;

  // sizes nonzero and within range, and every row fits in the pitch
  function automatic bit settings_usable();
    if (frame_w == 0 || frame_h == 0 || out_w == 0 || out_h == 0) return 1'b0;
    if (frame_w > MAX_DIM || frame_h > MAX_DIM || out_w > MAX_DIM || out_h > MAX_DIM)
      return 1'b0;
    return int'(row_pitch) >= 4 * int'(frame_w);
  endfunction

  // crop origin plus scaled coordinate, clamped to the last source pixel
  function automatic logic [COORD_W-1:0] nearest_src(longint unsigned idx,
                                                     longint unsigned origin,
                                                     longint unsigned span,
                                                     longint unsigned extent,
                                                     longint unsigned bound);
    longint unsigned v;
    v = origin + (idx * span) / extent;
    if (v > bound - 1) v = bound - 1;
    return v[COORD_W-1:0];
  endfunction

  function automatic void rebuild_luts();
    longint unsigned fw, fh, ow, oh, crop_w, crop_h, org_x, org_y;
    fw     = frame_w;
    fh     = frame_h;
    ow     = out_w;
    oh     = out_h;
    crop_w = fw;
    crop_h = fh;
    org_x  = 0;
    org_y  = 0;
    // frame relatively wider than the output: crop the sides, else top and bottom
    if (fw * oh > ow * fh) begin
      crop_w = (fh * ow) / oh;
      org_x  = (fw - crop_w) / 2;
    end else begin
      crop_h = (fw * oh) / ow;
      org_y  = (fh - crop_h) / 2;
    end
    for (int i = 0; i < int'(out_w); i++) col_lut[i] = nearest_src(i, org_x, crop_w, ow, fw);
    for (int i = 0; i < int'(out_h); i++) row_lut[i] = nearest_src(i, org_y, crop_h, oh, fh);
    luts_fresh = 1'b1;
  endfunction

  // expected result for one coordinate; rebuilds the maps first when stale,
  // even if the coordinate then falls outside the output area
  function automatic out_t map_coord(in_t c);
    out_t            r;
    longint unsigned off;
    r = '0;
    if (!settings_usable()) return r;
    if (!luts_fresh) rebuild_luts();
    if (c.out_column >= out_w || c.out_row >= out_h) return r;
    r.source_x    = col_lut[c.out_column];
    r.source_y    = row_lut[c.out_row];
    off           = 64'(r.source_y) * row_pitch + 64'(r.source_x) * 4;
    r.byte_offset = off[OFF_W-1:0];
    r.in_range    = 1'b1;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // reporting, idling control, drivers
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    if (mismatch_count < MAX_REPORTS)
      $display("%0t ns mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  task automatic set_idling(int mode);
    case (mode)
      IDLE_SENDER_LIGHT: begin
        sender_idle_pct    = 38;
        receiver_stall_pct = 54;
      end
      IDLE_SENDER_HEAVY: begin
        sender_idle_pct    = 54;
        receiver_stall_pct = 38;
      end
      default: begin
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
      end
    endcase
  endtask

  // offers one coordinate, optionally after a random gap, and books its expected
  // result at the accepting edge; valid is left high so back-to-back items keep it up
  task automatic send_coord(in_t c);
    logic taken;
    if ($urandom_range(99, 0) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99, 0) < sender_idle_pct);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= c;
    // ready is settled by the falling edge and holds until the next rising edge
    do begin
      @(negedge clk_i);
      taken = in_ready_o;
      @(posedge clk_i);
    end while (!taken);
    pending_maps.push_back(map_coord(c));
  endtask

  // stops offering coordinates and waits until every mapped pixel is back
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_maps.size() != 0) @(posedge clk_i);
  endtask

  // one register write; cfg_valid_i stays high for the next write
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    logic taken;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do begin
      @(negedge clk_i);
      taken = cfg_ready_o;
      @(posedge clk_i);
    end while (!taken);
    case (idx)
      REG_FRAME_WIDTH:     frame_w   = val[DIM_W-1:0];
      REG_FRAME_HEIGHT:    frame_h   = val[DIM_W-1:0];
      REG_OUTPUT_WIDTH:    out_w     = val[DIM_W-1:0];
      REG_OUTPUT_HEIGHT:   out_h     = val[DIM_W-1:0];
      REG_FRAME_ROW_PITCH: row_pitch = val;
      default: ;
    endcase
    // only decoded registers invalidate the maps
    if (idx <= REG_FRAME_ROW_PITCH) luts_fresh = 1'b0;
  endtask

  // full register set, written only once the block has drained
  task automatic set_frame(int fw, int fh, int ow, int oh, int pitch, bit spare = 1'b0);
    settle();
    write_reg(REG_FRAME_WIDTH,     CFG_DATA_W'(fw));
    write_reg(REG_FRAME_HEIGHT,    CFG_DATA_W'(fh));
    write_reg(REG_OUTPUT_WIDTH,    CFG_DATA_W'(ow));
    write_reg(REG_OUTPUT_HEIGHT,   CFG_DATA_W'(oh));
    write_reg(REG_FRAME_ROW_PITCH, CFG_DATA_W'(pitch));
    if (spare) begin
      write_reg(REG_SPARE_LO, '1);
      write_reg(REG_SPARE_HI, CFG_DATA_W'($urandom));
    end
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_xy(int col, int row);
    in_t c;
    c.out_column = COORD_W'(col);
    c.out_row    = COORD_W'(row);
    send_coord(c);
  endtask

  // ---------------------------------------------------------------------------
  // result check: sample at the falling edge, score at the accepting rising edge
  // ---------------------------------------------------------------------------
  logic result_fire;
  out_t result_seen;
  out_t result_want;

  always begin
    @(negedge clk_i);
    result_fire = rst_ni && out_valid_o && out_ready_i;
    result_seen = out_data_o;
    @(posedge clk_i);
    if (result_fire === 1'b1) begin
      if (pending_maps.size() == 0) begin
        report_mismatch("result with no coordinate outstanding", result_seen, 0);
      end else begin
        result_want = pending_maps.pop_front();
        if (result_seen.source_x !== result_want.source_x)
          report_mismatch("source_x", result_seen.source_x, result_want.source_x);
        if (result_seen.source_y !== result_want.source_y)
          report_mismatch("source_y", result_seen.source_y, result_want.source_y);
        if (result_seen.byte_offset !== result_want.byte_offset)
          report_mismatch("byte_offset", result_seen.byte_offset, result_want.byte_offset);
        if (result_seen.in_range !== result_want.in_range)
          report_mismatch("in_range", result_seen.in_range, result_want.in_range);
      end
    end
    // receiver backpressure for the next cycle
    out_ready_i <= ($urandom_range(99, 0) >= receiver_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // watchdog: ends the run after too many cycles with no transaction on any channel
  // ---------------------------------------------------------------------------
  initial begin : watchdog
    int   quiet;
    logic moved;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(negedge clk_i);
      moved = (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
              (cfg_valid_i && cfg_ready_o);
      @(posedge clk_i);
      quiet = (moved === 1'b1) ? 0 : quiet + 1;
    end
    $display("%0t ns no transaction for %0d cycles", $time, QUIET_LIMIT);
    $display("cover_fit_nearest_scaler_map regression: fail");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // all registers zero after reset: nothing maps
  task automatic test_unconfigured();
    send_xy(0, 0);
    send_xy(COORD_MAX, COORD_MAX);
  endtask

  // each way the settings can be unusable, one item apiece
  task automatic test_invalid_settings();
    set_frame(0, 16, 16, 16, 64);
    send_xy(1, 1);
    // height just past the largest supported size
    set_frame(16, MAX_DIM + 1, 16, 16, 64);
    send_xy(2, 3);
    // all data bits set on a size register
    set_frame(16, 16, 'hFFFF, 16, 64);
    send_xy(3, 2);
    set_frame(16, 16, 16, 0, 64);
    send_xy(0, 0);
    // pitch one byte short of a full row
    set_frame(16, 16, 16, 16, 63);
    send_xy(5, 5);
  endtask

  // one-pixel frame with the tightest pitch, coordinates just outside,
  // then writes to undecoded indexes that must change nothing
  task automatic test_minimal_frame();
    set_frame(1, 1, 1, 1, 4);
    send_xy(0, 0);
    send_xy(1, 0);
    send_xy(0, 1);
    set_frame(1, 1, 1, 1, 4, 1'b1);
    send_xy(0, 0);
  endtask

  // largest sizes and pitch, corners of the coordinate space
  task automatic test_full_size_frame();
    set_frame(MAX_DIM, MAX_DIM, MAX_DIM, MAX_DIM, 'hFFFF);
    send_xy(0, 0);
    send_xy(COORD_MAX, COORD_MAX);
    send_xy(COORD_MAX, 0);
    send_xy(0, COORD_MAX);
    send_xy(MAX_DIM / 2, 1);
  endtask

  // side crop, top and bottom crop, matching aspect and heavy upscaling
  task automatic test_crop_orientation();
    set_frame(1920, 1080, 100, 100, 7680);
    send_xy(0, 0);
    send_xy(99, 99);
    send_xy(100, 5);
    send_xy(5, 100);
    set_frame(480, 1920, 300, 120, 1920);
    send_xy(0, 0);
    send_xy(299, 119);
    set_frame(64, 32, 32, 16, 'hFFFF);
    send_xy(31, 15);
    set_frame(3, 5, 4000, 7, 12);
    send_xy(3999, 6);
  endtask

  // random frames: mostly small usable settings with coordinates inside the output
  // area, a few with sizes up to the maximum, a few broken; idling mode changes by thirds
  task automatic test_random_frames(int total);
    int  sent, batch, fw, fh, ow, oh, pitch, pick, bad;
    bit  spare;
    in_t c;
    sent = 0;
    while (sent < total) begin
      set_idling(sent * 3 / total);
      if ($urandom_range(99, 0) < 8) begin
        fw = $urandom_range(MAX_DIM, 1);
        fh = $urandom_range(MAX_DIM, 1);
        ow = $urandom_range(MAX_DIM, 1);
        oh = $urandom_range(MAX_DIM, 1);
      end else begin
        fw = $urandom_range(64, 1);
        fh = $urandom_range(64, 1);
        ow = $urandom_range(64, 1);
        oh = $urandom_range(64, 1);
      end
      pick = $urandom_range(99, 0);
      if (pick < 8) pitch = $urandom_range(65535, 0);
      else if (pick < 14) pitch = 4 * fw - 1;
      else if (pick < 30) pitch = 4 * fw;
      else pitch = 4 * fw + $urandom_range(4 * fw + 64, 0);
      if (pitch > 65535) pitch = 65535;
      // occasionally break one size: zero, too large, or junk in the upper bits
      if ($urandom_range(99, 0) < 6) begin
        pick = $urandom_range(2, 0);
        bad  = (pick == 0) ? 0 :
               (pick == 1) ? $urandom_range(8191, MAX_DIM + 1) : $urandom_range(65535, 0);
        case ($urandom_range(3, 0))
          0:       fw = bad;
          1:       fh = bad;
          2:       ow = bad;
          default: oh = bad;
        endcase
      end
      spare = ($urandom_range(99, 0) < 5);
      set_frame(fw, fh, ow, oh, pitch, spare);
      batch = $urandom_range(50, 10);
      repeat (batch) begin
        if ($urandom_range(99, 0) < 85 && out_w >= 1 && out_w <= MAX_DIM &&
            out_h >= 1 && out_h <= MAX_DIM) begin
          c.out_column = COORD_W'($urandom_range(int'(out_w) - 1, 0));
          c.out_row    = COORD_W'($urandom_range(int'(out_h) - 1, 0));
        end else begin
          c.out_column = COORD_W'($urandom_range(COORD_MAX, 0));
          c.out_row    = COORD_W'($urandom_range(COORD_MAX, 0));
        end
        send_coord(c);
      end
      sent += batch;
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_idling(IDLE_SENDER_LIGHT);
    test_unconfigured();
    test_invalid_settings();
    test_minimal_frame();
    test_full_size_frame();
    test_crop_orientation();
    test_random_frames(930);

    // drain, then give a stray result time to show up
    settle();
    repeat (LATENCY_PAUSE) @(posedge clk_i);
    if (pending_maps.size() != 0)
      report_mismatch("results never returned", 0, pending_maps.size());

    if (mismatch_count == 0) begin
      $display("cover_fit_nearest_scaler_map regression: pass");
    end else begin
      $display("cover_fit_nearest_scaler_map regression: fail");
    end
    $finish;
  end

endmodule
